### hw/rtl/cmbs_pkg.sv
package cmbs_pkg;

  // Default build of the block.
  localparam int CMBS_MAX_FACE_SIZE = 64;
  localparam int CMBS_CHANNEL_BITS  = 16;
  localparam int CMBS_BLEND_BITS    = 8;

  localparam int FACE_COUNT = 6;

  // Squared length threshold in units of 2^-28 (0.000001 rounded up).
  localparam int LENGTH_LIMIT = 269;
  // Largest component magnitude that can still give a short direction.
  localparam int SHORT_COMPONENT_MAX = 16;

  localparam int DIR_BITS  = 16;
  localparam int PORT_BITS = 16;
  localparam int CFG_BITS  = 7;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SELECT,
    ST_NUMER,
    ST_DIVIDE,
    ST_COORD,
    ST_READ,
    ST_HBLEND,
    ST_VBLEND,
    ST_DONE
  } cmbs_state_e;

endpackage

### hw/rtl/cmbs_texmem.sv
module cmbs_texmem
  import cmbs_pkg::*;
#(
  parameter int DEPTH = 24576,
  parameter int AW    = 15,
  parameter int DW    = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Single port: one write or one read per cycle, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/cmbs_div.sv
module cmbs_div
  import cmbs_pkg::*;
#(
  parameter int NW = 32,
  parameter int DW = 18,
  parameter int QW = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          idle_o,
  output logic [QW-1:0] quot_o
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] sh_q, sh_d;
  logic [DW-1:0] div_q;
  logic [DW:0]   trial;
  logic          ge;

  // Restoring division, one quotient bit per cycle. The upper dividend bits
  // start as the remainder, which is below the divisor as the quotient fits.
  always_comb begin
    trial = {rem_q, sh_q[QW-1]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? DW'(trial - {1'b0, div_q}) : DW'(trial);
    sh_d  = {sh_q[QW-2:0], ge};
    cnt_d = cnt_q - CW'(1);
    busy_d = (cnt_q != CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QW);
    end else if (busy_q) begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DW'(dividend_i[NW-1:QW]);
      sh_q  <= dividend_i[QW-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign idle_o = ~busy_q;
  assign quot_o = sh_q;

endmodule

### hw/rtl/cube_map_bilinear_sampler.sv
// Cube map sampler with six square faces of RGBA texels held in one
// single-port texel memory. A write transfer stores one texel and gives no
// result. A sample transfer picks a face from the major axis of the
// direction, finds the face position by two iterative dividers running
// side by side (one quotient bit per cycle, BLEND_BITS plus the face size
// bits in all), reads the four neighbouring texels one after another
// through the one memory port and blends them across x, then across y. A
// sample with face size zero or a very short direction skips the division
// and the reads and gives an all-zero result. One item is worked at a
// time; the result register lets the next transfer in while a result
// still waits. The texel memory is not cleared: a texel read before it
// has been written gives no defined value. face_size sits at byte address
// 0 of the APB port.
module cube_map_bilinear_sampler
  import cmbs_pkg::*;
#(
  parameter int MAX_FACE_SIZE = CMBS_MAX_FACE_SIZE,
  parameter int CHANNEL_BITS  = CMBS_CHANNEL_BITS,
  parameter int BLEND_BITS    = CMBS_BLEND_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [2:0]           face_i,
  input  logic [5:0]           texel_x_i,
  input  logic [5:0]           texel_y_i,
  input  logic [15:0]          red_in_i,
  input  logic [15:0]          green_in_i,
  input  logic [15:0]          blue_in_i,
  input  logic [15:0]          alpha_in_i,
  input  logic signed [15:0]   dir_x_i,
  input  logic signed [15:0]   dir_y_i,
  input  logic signed [15:0]   dir_z_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [15:0]          red_out_o,
  output logic [15:0]          green_out_o,
  output logic [15:0]          blue_out_o,
  output logic [15:0]          alpha_out_o,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int CB        = CHANNEL_BITS;
  localparam int BB        = BLEND_BITS;
  localparam int MW        = 4 * CB;
  localparam int FACE_WORDS = MAX_FACE_SIZE * MAX_FACE_SIZE;
  localparam int DEPTH     = FACE_COUNT * FACE_WORDS;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW        = $clog2(MAX_FACE_SIZE + 1);
  localparam int MAGW      = DIR_BITS + 1;
  localparam int TW        = MAGW + SW;
  localparam int NW        = TW + BB;
  localparam int DVW       = MAGW + 1;
  localparam int QW        = SW + BB;
  localparam int LW        = CB + BB + 2;
  localparam logic [BB:0] BLEND_ONE = (BB + 1)'(1) << BB;

  cmbs_state_e state_q, state_d;

  // Configuration register.
  logic [CFG_BITS-1:0] face_size_q;
  logic [SW-1:0]       size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_size_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      face_size_q <= pwdata[CFG_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(face_size_q);

  // A face size beyond the store acts as the largest one.
  assign size = (32'(face_size_q) > 32'(MAX_FACE_SIZE)) ? SW'(MAX_FACE_SIZE)
                                                        : SW'(face_size_q);

  logic in_xfer, wr_ok, mem_we;
  logic [AW-1:0] wr_addr, rd_addr, mem_addr;
  logic [MW-1:0] wr_data, mem_rdata;

  assign in_xfer = in_valid_i && in_ready_o;
  // Writes to a face that does not exist or beyond the store are dropped.
  assign wr_ok   = (32'(face_i) < 32'(FACE_COUNT))
                && (32'(texel_x_i) < 32'(MAX_FACE_SIZE))
                && (32'(texel_y_i) < 32'(MAX_FACE_SIZE));
  assign wr_addr = AW'(face_i) * AW'(FACE_WORDS) + AW'(texel_y_i) * AW'(MAX_FACE_SIZE)
                 + AW'(texel_x_i);
  assign wr_data = {alpha_in_i[CB-1:0], blue_in_i[CB-1:0],
                    green_in_i[CB-1:0], red_in_i[CB-1:0]};

  // Sample datapath registers.
  logic signed [DIR_BITS-1:0] dx_q, dy_q, dz_q;
  logic [2:0]                 face_q;
  logic [MAGW-1:0]            major_q;
  logic signed [MAGW:0]       nu_q, nv_q;
  logic                       zero_q;
  logic [SW-1:0]              x0_q, x1_q, y0_q, y1_q;
  logic [BB-1:0]              fx_q, fy_q;
  logic [2:0]                 rd_cnt_q;
  logic [MW-1:0]              tex_q [4];
  logic [CB-1:0]              top_q [4];
  logic [CB-1:0]              bot_q [4];
  logic [CB-1:0]              res_q [4];

  // Face selection and the short direction test.
  logic [MAGW-1:0]      ax, ay, az, major_d;
  logic signed [MAGW:0] sx, sy, sz, nu_d, nv_d;
  logic [2:0]           face_d;
  logic [9:0]           qx, qy, qz;
  logic [11:0]          len_sq;
  logic                 is_short;

  always_comb begin
    ax = dx_q[DIR_BITS-1] ? MAGW'(~{1'b1, dx_q} + 1'b1) : {1'b0, dx_q};
    ay = dy_q[DIR_BITS-1] ? MAGW'(~{1'b1, dy_q} + 1'b1) : {1'b0, dy_q};
    az = dz_q[DIR_BITS-1] ? MAGW'(~{1'b1, dz_q} + 1'b1) : {1'b0, dz_q};
    sx = (MAGW + 1)'(dx_q);
    sy = (MAGW + 1)'(dy_q);
    sz = (MAGW + 1)'(dz_q);
    if (ax >= ay && ax >= az) begin
      major_d = ax;
      nv_d    = -sy;
      face_d  = dx_q[DIR_BITS-1] ? FACE_NEG_X : FACE_POS_X;
      nu_d    = dx_q[DIR_BITS-1] ? sz : -sz;
    end else if (ay >= az) begin
      major_d = ay;
      nu_d    = sx;
      face_d  = dy_q[DIR_BITS-1] ? FACE_NEG_Y : FACE_POS_Y;
      nv_d    = dy_q[DIR_BITS-1] ? -sz : sz;
    end else begin
      major_d = az;
      nv_d    = -sy;
      face_d  = dz_q[DIR_BITS-1] ? FACE_NEG_Z : FACE_POS_Z;
      nu_d    = dz_q[DIR_BITS-1] ? -sx : sx;
    end
    // Any component above the small bound already passes the threshold,
    // so only five-bit squares are needed.
    qx = 10'(ax[4:0]) * 10'(ax[4:0]);
    qy = 10'(ay[4:0]) * 10'(ay[4:0]);
    qz = 10'(az[4:0]) * 10'(az[4:0]);
    len_sq = 12'(qx) + 12'(qy) + 12'(qz);
    is_short = (32'(ax) <= SHORT_COMPONENT_MAX) && (32'(ay) <= SHORT_COMPONENT_MAX)
            && (32'(az) <= SHORT_COMPONENT_MAX) && (32'(len_sq) < LENGTH_LIMIT);
  end

  // Dividend ((n + m) * S - m) << BB, zero where not positive.
  logic signed [MAGW:0] su_full, sv_full;
  logic [TW-1:0]        tu, tv;
  logic [NW-1:0]        dvd_u, dvd_v;
  logic [DVW-1:0]       divisor;

  always_comb begin
    su_full = nu_q + $signed({1'b0, major_q});
    sv_full = nv_q + $signed({1'b0, major_q});
    tu = TW'(su_full[MAGW-1:0]) * TW'(size);
    tv = TW'(sv_full[MAGW-1:0]) * TW'(size);
    dvd_u = (tu > TW'(major_q)) ? {tu - TW'(major_q), BB'(0)} : '0;
    dvd_v = (tv > TW'(major_q)) ? {tv - TW'(major_q), BB'(0)} : '0;
    divisor = {major_q, 1'b0};
  end

  logic          div_start, u_idle, v_idle;
  logic [QW-1:0] qu, qv;

  assign div_start = (state_q == ST_NUMER);

  cmbs_div #(.NW(NW), .DW(DVW), .QW(QW)) u_div_u (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_u),
    .divisor_i(divisor), .idle_o(u_idle), .quot_o(qu)
  );

  cmbs_div #(.NW(NW), .DW(DVW), .QW(QW)) u_div_v (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_v),
    .divisor_i(divisor), .idle_o(v_idle), .quot_o(qv)
  );

  // Clamp to the last texel centre and split into texel and fraction.
  logic [QW-1:0] limit, px, py;
  logic [SW-1:0] x0_d, y0_d, x1_d, y1_d, size_m1;

  always_comb begin
    size_m1 = size - SW'(1);
    limit   = QW'(size_m1) << BB;
    px      = (qu > limit) ? limit : qu;
    py      = (qv > limit) ? limit : qv;
    x0_d    = px[QW-1:BB];
    y0_d    = py[QW-1:BB];
    x1_d    = (x0_d < size_m1) ? x0_d + SW'(1) : size_m1;
    y1_d    = (y0_d < size_m1) ? y0_d + SW'(1) : size_m1;
  end

  // Neighbour order: (x0,y0), (x1,y0), (x0,y1), (x1,y1).
  logic [SW-1:0] rx, ry;
  logic [1:0]    cap_idx;

  assign rx      = rd_cnt_q[0] ? x1_q : x0_q;
  assign ry      = rd_cnt_q[1] ? y1_q : y0_q;
  assign rd_addr = AW'(face_q) * AW'(FACE_WORDS) + AW'(ry) * AW'(MAX_FACE_SIZE) + AW'(rx);
  assign cap_idx = 2'(rd_cnt_q - 3'd1);

  function automatic logic [CB-1:0] lerp(input logic [CB-1:0] a,
                                         input logic [CB-1:0] b,
                                         input logic [BB-1:0] f);
    logic [LW-1:0] s;
    s = LW'(a) * LW'(BLEND_ONE - {1'b0, f}) + LW'(b) * LW'(f) + LW'(BLEND_ONE >> 1);
    return s[BB+CB-1:BB];
  endfunction

  logic out_load;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer && command_i == CMD_SAMPLE) state_d = ST_SELECT;
      ST_SELECT: state_d = (size == '0 || is_short) ? ST_DONE : ST_NUMER;
      ST_NUMER:  state_d = ST_DIVIDE;
      ST_DIVIDE: if (u_idle && v_idle) state_d = ST_COORD;
      ST_COORD:  state_d = ST_READ;
      ST_READ:   if (rd_cnt_q == 3'd4) state_d = ST_HBLEND;
      ST_HBLEND: state_d = ST_VBLEND;
      ST_VBLEND: state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = rd_addr;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        mem_we     = in_xfer && command_i == CMD_WRITE && wr_ok;
        mem_addr   = wr_addr;
      end
      ST_DONE: out_load = !out_valid_o || out_ready_i;
      default: ;
    endcase
  end

  cmbs_texmem #(.DEPTH(DEPTH), .AW(AW), .DW(MW)) u_texmem (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(wr_data), .rdata_o(mem_rdata)
  );

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_COORD) begin
        rd_cnt_q <= '0;
      end else if (state_q == ST_READ) begin
        rd_cnt_q <= rd_cnt_q + 3'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [CB-1:0] out_q [4];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_xfer) begin
      dx_q <= dir_x_i;
      dy_q <= dir_y_i;
      dz_q <= dir_z_i;
    end
    if (state_q == ST_SELECT) begin
      face_q  <= face_d;
      major_q <= major_d;
      nu_q    <= nu_d;
      nv_q    <= nv_d;
      zero_q  <= (size == '0) || is_short;
    end
    if (state_q == ST_COORD) begin
      x0_q <= x0_d;
      x1_q <= x1_d;
      y0_q <= y0_d;
      y1_q <= y1_d;
      fx_q <= px[BB-1:0];
      fy_q <= py[BB-1:0];
    end
    if (state_q == ST_READ && rd_cnt_q != 3'd0) begin
      tex_q[cap_idx] <= mem_rdata;
    end
    for (int c = 0; c < 4; c++) begin
      if (state_q == ST_HBLEND) begin
        top_q[c] <= lerp(tex_q[0][c*CB +: CB], tex_q[1][c*CB +: CB], fx_q);
        bot_q[c] <= lerp(tex_q[2][c*CB +: CB], tex_q[3][c*CB +: CB], fx_q);
      end
      if (state_q == ST_VBLEND) begin
        res_q[c] <= lerp(top_q[c], bot_q[c], fy_q);
      end
      if (out_load) begin
        out_q[c] <= zero_q ? '0 : res_q[c];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = PORT_BITS'(out_q[0]);
  assign green_out_o = PORT_BITS'(out_q[1]);
  assign blue_out_o  = PORT_BITS'(out_q[2]);
  assign alpha_out_o = PORT_BITS'(out_q[3]);

  // The two dividers are started together and must finish together.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_idle == v_idle)
    else $error("face position dividers out of step");

  // The texel memory is only written between samples.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_IDLE && command_i == CMD_WRITE)
    else $error("texel write outside idle");

  // Neighbours stay on the face in use.
  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HBLEND && !zero_q |-> x1_q < size && y1_q < size
                                        && x0_q <= x1_q && y0_q <= y1_q)
    else $error("texel neighbour outside face");

  // A finished result is never lost while the output still holds one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten");

endmodule

### sim/cube_map_bilinear_sampler_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the cube map sampler.
// An initial block builds a list of texel writes and direction samples; a
// clocked driver offers them to the block in bursts with random gaps, and a
// clocked monitor takes the results under a stall pattern of its own. Every
// sample that is accepted is run through a local predictor at once, and the
// expected colour is queued for the monitor to compare against.
module cube_map_bilinear_sampler_tb;
  import cmbs_pkg::*;

  localparam int MFS   = CMBS_MAX_FACE_SIZE;
  localparam int BB    = CMBS_BLEND_BITS;
  localparam int DEPTH = FACE_COUNT * MFS * MFS;
  // Edge of the square corner of each face that is written up front.
  localparam int FILL_EDGE = 6;

  typedef struct packed {
    logic              command;
    logic [2:0]        face;
    logic [5:0]        tx;
    logic [5:0]        ty;
    logic [15:0]       r, g, b, a;
    logic signed [15:0] dx, dy, dz;
  } texel_req_t;

  typedef struct packed {
    logic [15:0] r, g, b, a;
  } colour_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = 1'b0;
  logic [2:0]  face_i = '0;
  logic [5:0]  texel_x_i = '0, texel_y_i = '0;
  logic [15:0] red_in_i = '0, green_in_i = '0, blue_in_i = '0, alpha_in_i = '0;
  logic signed [15:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] red_out_o, green_out_o, blue_out_o, alpha_out_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cube_map_bilinear_sampler uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the block's state, kept in step with accepted transfers.
  logic [63:0] texel_mem [DEPTH];
  bit          texel_written [DEPTH];
  logic [6:0]  face_size_q = '0;

  texel_req_t pending_reqs[$];
  colour_t    expected_colours[$];

  int  error_count = 0;
  int  samples_checked = 0;
  int  zero_results = 0;
  int  writes_sent = 0;
  bit  sender_hold = 1'b0;   // initial block pauses the driver through this
  int  rx_hold_cycles = 0;   // long stall that the monitor counts itself

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [63:0] face_coord(int num, int major, int size);
    longint numer, q, limit;
    numer = (longint'(num) + major) * size - major;
    limit = longint'(size - 1) << BB;
    if (numer <= 0) return 0;
    q = (numer << BB) / (longint'(major) * 2);
    return (q > limit) ? limit : q;
  endfunction

  function automatic logic [15:0] blend(logic [15:0] lo, logic [15:0] hi, int frac);
    longint s;
    s = longint'(lo) * ((1 << BB) - frac) + longint'(hi) * frac + (1 << (BB - 1));
    return 16'(s >> BB);
  endfunction

  function automatic int texel_addr(int f, int x, int y);
    return (f * MFS + y) * MFS + x;
  endfunction

  // Finds the face, the four neighbours and the blend fractions of a sample
  // at the current face size; false when the result is all zero because the
  // map is invalid or the direction is too short to trust.
  function automatic bit locate(input texel_req_t req, output int fsel,
                                output int x0, output int y0, output int x1,
                                output int y1, output int fx, output int fy);
    int size, ax, ay, az, major, nu, nv;
    longint len2;
    logic [63:0] px, py;
    fsel = 0; x0 = 0; y0 = 0; x1 = 0; y1 = 0; fx = 0; fy = 0;
    size = (face_size_q > MFS) ? MFS : face_size_q;
    len2 = longint'(req.dx) * req.dx + longint'(req.dy) * req.dy
           + longint'(req.dz) * req.dz;
    if (size == 0 || len2 < LENGTH_LIMIT) return 1'b0;
    ax = (req.dx < 0) ? -int'(req.dx) : int'(req.dx);
    ay = (req.dy < 0) ? -int'(req.dy) : int'(req.dy);
    az = (req.dz < 0) ? -int'(req.dz) : int'(req.dz);
    if (ax >= ay && ax >= az) begin
      major = ax; nv = -int'(req.dy);
      if (req.dx >= 0) begin fsel = FACE_POS_X; nu = -int'(req.dz); end
      else begin fsel = FACE_NEG_X; nu = req.dz; end
    end else if (ay >= az) begin
      major = ay; nu = req.dx;
      if (req.dy >= 0) begin fsel = FACE_POS_Y; nv = req.dz; end
      else begin fsel = FACE_NEG_Y; nv = -int'(req.dz); end
    end else begin
      major = az; nv = -int'(req.dy);
      if (req.dz >= 0) begin fsel = FACE_POS_Z; nu = req.dx; end
      else begin fsel = FACE_NEG_Z; nu = -int'(req.dx); end
    end
    px = face_coord(nu, major, size);
    py = face_coord(nv, major, size);
    x0 = int'(px >> BB); y0 = int'(py >> BB);
    fx = int'(px) & ((1 << BB) - 1);
    fy = int'(py) & ((1 << BB) - 1);
    x1 = (x0 + 1 < size) ? x0 + 1 : size - 1;
    y1 = (y0 + 1 < size) ? y0 + 1 : size - 1;
    return 1'b1;
  endfunction

  // Works out the filtered colour a sample must give.
  function automatic colour_t predict_colour(texel_req_t req);
    colour_t res;
    int fsel, x0, y0, x1, y1, fx, fy;
    bit reads;
    logic [63:0] t00, t10, t01, t11;
    logic [15:0] top, bot;
    res = '0;
    reads = locate(req, fsel, x0, y0, x1, y1, fx, fy);
    if (!reads) return res;
    t00 = texel_mem[texel_addr(fsel, x0, y0)];
    t10 = texel_mem[texel_addr(fsel, x1, y0)];
    t01 = texel_mem[texel_addr(fsel, x0, y1)];
    t11 = texel_mem[texel_addr(fsel, x1, y1)];
    for (int c = 0; c < 4; c++) begin
      top = blend(t00[16*c +: 16], t10[16*c +: 16], fx);
      bot = blend(t01[16*c +: 16], t11[16*c +: 16], fx);
      res[16*(3-c) +: 16] = blend(top, bot, fy);
    end
    return res;
  endfunction

  function automatic void apply_transfer(texel_req_t req);
    int addr;
    if (req.command == CMD_WRITE) begin
      if (req.face >= FACE_COUNT) return;
      addr = texel_addr(req.face, req.tx, req.ty);
      texel_mem[addr] = {req.a, req.b, req.g, req.r};
      texel_written[addr] = 1'b1;
    end else begin
      expected_colours.push_back(predict_colour(req));
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them.
  // ---------------------------------------------------------------------
  int burst_left = 0, gap_left = 0;

  always @(posedge clk_i) begin
    texel_req_t nxt;
    bit offer;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        apply_transfer(pending_reqs.pop_front());
      end
      // valid stays up while the current item has not yet been taken
      offer = 1'b0;
      if (in_valid_i && !in_ready_o) offer = 1'b1;
      else if (!sender_hold && pending_reqs.size() > 0) begin
        if (gap_left > 0) gap_left--;
        else begin
          offer = 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
      end
      in_valid_i <= offer;
      if (offer) begin
        nxt = pending_reqs[0];
        command_i  <= nxt.command;
        face_i     <= nxt.face;
        texel_x_i  <= nxt.tx;
        texel_y_i  <= nxt.ty;
        red_in_i   <= nxt.r;
        green_in_i <= nxt.g;
        blue_in_i  <= nxt.b;
        alpha_in_i <= nxt.a;
        dir_x_i    <= nxt.dx;
        dir_y_i    <= nxt.dy;
        dir_z_i    <= nxt.dz;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compares each result transfer with the oldest expectation and
  // stalls on its own pattern, plus one long hold requested by the stimulus.
  // ---------------------------------------------------------------------
  int stall_mode = 0;

  always @(posedge clk_i) begin
    colour_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{red_out_o, green_out_o, blue_out_o, alpha_out_o};
        if (expected_colours.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, got);
          error_count++;
        end else begin
          want = expected_colours.pop_front();
          samples_checked++;
          if (want == '0) zero_results++;
          if (got.r !== want.r) begin
            $display("%0t: red expected %h actual %h", $time, want.r, got.r);
            error_count++;
          end
          if (got.g !== want.g) begin
            $display("%0t: green expected %h actual %h", $time, want.g, got.g);
            error_count++;
          end
          if (got.b !== want.b) begin
            $display("%0t: blue expected %h actual %h", $time, want.b, got.b);
            error_count++;
          end
          if (got.a !== want.a) begin
            $display("%0t: alpha expected %h actual %h", $time, want.a, got.a);
            error_count++;
          end
        end
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic apb_write(logic [6:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'd0; pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    face_size_q = value;
  endtask

  // Lets the block drain fully before touching the register; writes give
  // no result, so a further latency allowance follows the last result.
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i || expected_colours.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic texel_req_t write_req(int f, int x, int y, bit rnd_colour);
    texel_req_t w;
    w = '0;
    w.command = CMD_WRITE;
    w.face = 3'(f); w.tx = 6'(x); w.ty = 6'(y);
    w.r = rnd_colour ? 16'($urandom) : 16'hFFFF;
    w.g = rnd_colour ? 16'($urandom) : 16'h0000;
    w.b = rnd_colour ? 16'($urandom) : 16'h8001;
    w.a = rnd_colour ? 16'($urandom) : 16'h7FFE;
    w.dx = 16'($urandom); w.dy = 16'($urandom); w.dz = 16'($urandom);
    return w;
  endfunction

  function automatic texel_req_t sample_req(int x, int y, int z);
    texel_req_t s;
    s = '0;
    s.command = CMD_SAMPLE;
    s.face = 3'($urandom); s.tx = 6'($urandom); s.ty = 6'($urandom);
    s.r = 16'($urandom); s.g = 16'($urandom);
    s.b = 16'($urandom); s.a = 16'($urandom);
    s.dx = 16'(x); s.dy = 16'(y); s.dz = 16'(z);
    return s;
  endfunction

  function automatic int rand_edge();
    case ($urandom_range(0, 3))
      0: return 32767;
      1: return -32768;
      2: return 16384;
      default: return -16384;
    endcase
  endfunction

  function automatic int signed_rand();
    logic signed [15:0] v;
    v = 16'($urandom);
    return v;
  endfunction

  // A direction close to a cube corner, so that on large faces it lands
  // near a face corner; one in four sign choices hits the low corner.
  function automatic texel_req_t corner_sample();
    int m, p, q, sm, sp, sq;
    m = $urandom_range(8192, 32767);
    p = m - int'($urandom_range(0, m / 6));
    q = m - int'($urandom_range(0, m / 6));
    sm = $urandom_range(0, 1) ? m : -m;
    sp = $urandom_range(0, 1) ? p : -p;
    sq = $urandom_range(0, 1) ? q : -q;
    case ($urandom_range(0, 2))
      0: return sample_req(sm, sp, sq);
      1: return sample_req(sp, sm, sq);
      default: return sample_req(sp, sq, sm);
    endcase
  endfunction

  // True when every texel the sample reads has been written already.
  function automatic bit reads_written(texel_req_t req);
    int fsel, x0, y0, x1, y1, fx, fy;
    bit reads;
    reads = locate(req, fsel, x0, y0, x1, y1, fx, fy);
    if (!reads) return 1'b1;
    return texel_written[texel_addr(fsel, x0, y0)]
        && texel_written[texel_addr(fsel, x1, y0)]
        && texel_written[texel_addr(fsel, x0, y1)]
        && texel_written[texel_addr(fsel, x1, y1)];
  endfunction

  // Keeps a sample only if it reads written texels, else tries corner
  // directions and in the end falls back to a short direction.
  function automatic texel_req_t checked_sample(texel_req_t cand);
    texel_req_t s;
    s = cand;
    for (int i = 0; i < 64 && !reads_written(s); i++) s = corner_sample();
    if (!reads_written(s)) s = sample_req(9, 9, 9);
    return s;
  endfunction

  // Fills the low corner of every face so that samples at small face sizes,
  // and corner samples at large ones, never fall on an unwritten texel.
  task automatic fill_store();
    for (int f = 0; f < FACE_COUNT; f++)
      for (int y = 0; y < FILL_EDGE; y++)
        for (int x = 0; x < FILL_EDGE; x++) begin
          pending_reqs.push_back(write_req(f, x, y, 1'b1));
          writes_sent++;
        end
    wait_drained();
  endtask

  // Random phase at one face size: mostly samples, some writes including
  // ignored bad faces.
  task automatic random_phase(int n_items);
    texel_req_t it;
    int kind;
    for (int i = 0; i < n_items; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        it = write_req($urandom_range(0, 7), $urandom_range(0, 63),
                       $urandom_range(0, 63), 1'b1);
        writes_sent++;
      end else if (kind == 3) begin
        it = checked_sample(sample_req(int'($urandom_range(0, 30)) - 15,
                                       int'($urandom_range(0, 30)) - 15,
                                       int'($urandom_range(0, 30)) - 15));
      end else begin
        it = checked_sample(sample_req($urandom_range(0, 1) ? signed_rand() : rand_edge(),
                                       $urandom_range(0, 1) ? signed_rand() : rand_edge(),
                                       $urandom_range(0, 1) ? signed_rand() : rand_edge()));
      end
      pending_reqs.push_back(it);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int sizes[6] = '{1, 64, 127, 2, 17, 33};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Invalid map: face size still zero after reset.
    pending_reqs.push_back(sample_req(16384, 0, 0));
    pending_reqs.push_back(sample_req(-32768, 32767, 100));
    wait_drained();

    fill_store();

    // Directed samples on a small face that lies wholly in the filled corner.
    apb_write(7'd4);
    pending_reqs.push_back(write_req(FACE_POS_X, 0, 0, 1'b0));
    pending_reqs.push_back(write_req(FACE_NEG_Z, 63, 63, 1'b0));
    pending_reqs.push_back(write_req(6, 1, 1, 1'b1));   // bad face, ignored
    pending_reqs.push_back(write_req(7, 2, 2, 1'b1));
    writes_sent += 4;
    pending_reqs.push_back(sample_req(16384, 0, 0));
    pending_reqs.push_back(sample_req(-16384, 0, 0));
    pending_reqs.push_back(sample_req(0, 16384, 0));
    pending_reqs.push_back(sample_req(0, -16384, 0));
    pending_reqs.push_back(sample_req(0, 0, 16384));
    pending_reqs.push_back(sample_req(0, 0, -16384));
    pending_reqs.push_back(sample_req(100, 100, 100));     // ties favour x
    pending_reqs.push_back(sample_req(-100, 100, -100));
    pending_reqs.push_back(sample_req(0, 200, -200));      // y beats z on tie
    pending_reqs.push_back(sample_req(32767, 32767, -32768));
    pending_reqs.push_back(sample_req(-32768, -32768, -32768));
    pending_reqs.push_back(sample_req(9, 9, 9));           // short direction
    pending_reqs.push_back(sample_req(17, 0, 0));          // just long enough
    pending_reqs.push_back(sample_req(0, 0, 0));
    pending_reqs.push_back(sample_req(1000, 999, -999));
    wait_drained();

    // Random phases over several face sizes, including above the maximum.
    foreach (sizes[k]) begin
      apb_write(7'(sizes[k]));
      random_phase(150);
      if (k == 1) begin
        // Hold the result side off long enough for the input to back up.
        rx_hold_cycles = 300;
      end
      wait_drained();
    end

    // Sender pauses while the face size is written and a phase is queued, then resumes.
    sender_hold = 1'b1;
    apb_write(7'd5);
    random_phase(80);
    repeat (20) @(posedge clk_i);
    sender_hold = 1'b0;
    wait_drained();
    apb_write(7'd0);
    random_phase(30);
    wait_drained();

    $display("Covered %0d texel writes and %0d checked samples (%0d all-zero).",
             writes_sent, samples_checked, zero_results);
    $display("Face sizes 0, 1, 2, 4, 5, 17, 33, 64 and 127 were used.");
    if (error_count == 0 && expected_colours.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
